[rtl/trial_division_prime_classifier_core_assert.svh]
// Assertion macros shared by the trial division classifier RTL.
`ifndef TRIAL_DIVISION_PRIME_CLASSIFIER_CORE_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_CLASSIFIER_CORE_ASSERT_SVH

// Clocked assertion, disabled while reset is high.
`define TDPC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define TDPC_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/tdpc_pkg.sv]
// Package: shared constants of the trial division classifier.
`default_nettype none
package tdpc_pkg;
   localparam int VALUE_BITS_DEFAULT = 32;

   localparam logic [1:0] VERDICT_SPECIAL   = 2'd0;
   localparam logic [1:0] VERDICT_PRIME     = 2'd1;
   localparam logic [1:0] VERDICT_COMPOSITE = 2'd2;
endpackage
`default_nettype wire

[rtl/tdpc_sub_unit.sv]
// Shared subtract and compare unit used by the root, range check and divide steps.
`default_nettype none
module tdpc_sub_unit #(
   parameter int WIDTH = tdpc_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic [WIDTH-1:0] a,
   input  wire logic [WIDTH-1:0] b,
   output logic      [WIDTH-1:0] diff,
   output logic                  no_borrow
);
   logic [WIDTH:0] wide;

   assign wide      = {1'b0, a} - {1'b0, b};
   assign diff      = wide[WIDTH-1:0];
   assign no_borrow = ~wide[WIDTH];
endmodule
`default_nettype wire

[rtl/trial_division_prime_classifier_core.sv]
// Top level: trial division prime classifier with one shared subtractor.
`default_nettype none
// Classifies one unsigned word per request: 0 and 1 are special (factor 0), otherwise
// the integer square root is formed bit by bit and the divisors 2 up to the root are
// tried with a restoring bit-serial divider; the first exact divisor is the factor
// (composite), else the factor is the number (prime). The root, range check and divide
// steps run through a single shared subtract/compare unit, one step per cycle. A special
// word goes from accept straight to the finish state. Otherwise the steps are: accept,
// the root steps, per divisor tried a range check, a divide step per word bit and a zero
// test, one closing range check for primes, and the result load. A 32-bit prime near
// 2^32 tries about 65535 divisors. The request side is ready only between items; a
// finished result waits in the output register while the next word is accepted.
module trial_division_prime_classifier_core #(
   parameter int VALUE_BITS = tdpc_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [VALUE_BITS-1:0] req_number,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [1:0]                 rsp_verdict,
   output logic [VALUE_BITS-1:0]      rsp_smallest_factor
);
   import tdpc_pkg::*;

   `include "trial_division_prime_classifier_core_assert.svh"

   localparam int TOP_SHIFT = ((VALUE_BITS - 1) / 2) * 2;
   localparam int ROOT_BITS = (VALUE_BITS + 1) / 2;
   localparam int DIV_BITS  = ROOT_BITS + 1;
   localparam int CNT_BITS  = $clog2(VALUE_BITS);

   localparam logic [VALUE_BITS-1:0] PROBE_INIT = VALUE_BITS'(1) << TOP_SHIFT;
   localparam logic [CNT_BITS-1:0]   CNT_LAST   = CNT_BITS'(VALUE_BITS - 1);
   localparam logic [DIV_BITS-1:0]   DIV_FIRST  = DIV_BITS'(2);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ROOT   = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_TEST   = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [VALUE_BITS-1:0] number_ff, number_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [VALUE_BITS-1:0] probe_ff, probe_in;
   logic [ROOT_BITS-1:0]  limit_ff, limit_in;
   logic [DIV_BITS-1:0]   div_ff, div_in;
   logic [CNT_BITS-1:0]   bit_idx_ff, bit_idx_in;
   logic [1:0]            verdict_ff, verdict_in;
   logic [VALUE_BITS-1:0] factor_ff, factor_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_verdict_ff, rsp_verdict_in;
   logic [VALUE_BITS-1:0] rsp_factor_ff, rsp_factor_in;

   logic [VALUE_BITS-1:0] sub_a, sub_b, sub_diff;
   logic                  sub_ge;
   logic [VALUE_BITS-1:0] shifted;
   logic [VALUE_BITS-1:0] acc_next;
   logic                  req_fire;

   assign req_ready           = (state_ff == ST_IDLE);
   assign req_fire            = req_valid && req_ready;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_verdict         = rsp_verdict_ff;
   assign rsp_smallest_factor = rsp_factor_ff;

   assign shifted = {rem_ff[VALUE_BITS-2:0], number_ff[bit_idx_ff]};

   always_comb begin
      case (state_ff)
         ST_ROOT: begin
            sub_a = rem_ff;
            sub_b = acc_ff | probe_ff;
         end
         ST_CHECK: begin
            sub_a = VALUE_BITS'(limit_ff);
            sub_b = VALUE_BITS'(div_ff);
         end
         ST_DIV: begin
            sub_a = shifted;
            sub_b = VALUE_BITS'(div_ff);
         end
         default: begin
            sub_a = '0;
            sub_b = '0;
         end
      endcase
   end

   tdpc_sub_unit #(
      .WIDTH (VALUE_BITS)
   ) u_sub (
      .a         (sub_a),
      .b         (sub_b),
      .diff      (sub_diff),
      .no_borrow (sub_ge)
   );

   // acc and probe never overlap, so the root adds reduce to ORs
   assign acc_next = sub_ge ? ((acc_ff >> 1) | probe_ff) : (acc_ff >> 1);

   always_comb begin
      state_in       = state_ff;
      number_in      = number_ff;
      rem_in         = rem_ff;
      acc_in         = acc_ff;
      probe_in       = probe_ff;
      limit_in       = limit_ff;
      div_in         = div_ff;
      bit_idx_in     = bit_idx_ff;
      verdict_in     = verdict_ff;
      factor_in      = factor_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_factor_in  = rsp_factor_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               number_in = req_number;
               rem_in    = req_number;
               acc_in    = '0;
               probe_in  = PROBE_INIT;
               if (req_number[VALUE_BITS-1:1] == '0) begin
                  verdict_in = VERDICT_SPECIAL;
                  factor_in  = '0;
                  state_in   = ST_FINISH;
               end else begin
                  state_in = ST_ROOT;
               end
            end
         end
         ST_ROOT: begin
            if (sub_ge) begin
               rem_in = sub_diff;
            end
            acc_in   = acc_next;
            probe_in = probe_ff >> 2;
            if (probe_ff[0]) begin
               limit_in = acc_next[ROOT_BITS-1:0];
               div_in   = DIV_FIRST;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sub_ge) begin
               rem_in     = '0;
               bit_idx_in = CNT_LAST;
               state_in   = ST_DIV;
            end else begin
               verdict_in = VERDICT_PRIME;
               factor_in  = number_ff;
               state_in   = ST_FINISH;
            end
         end
         ST_DIV: begin
            rem_in     = sub_ge ? sub_diff : shifted;
            bit_idx_in = bit_idx_ff - CNT_BITS'(1);
            if (bit_idx_ff == '0) begin
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (rem_ff == '0) begin
               verdict_in = VERDICT_COMPOSITE;
               factor_in  = VALUE_BITS'(div_ff);
               state_in   = ST_FINISH;
            end else begin
               div_in   = div_ff + DIV_BITS'(1);
               state_in = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = verdict_ff;
               rsp_factor_in  = factor_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      number_ff      <= number_in;
      rem_ff         <= rem_in;
      acc_ff         <= acc_in;
      probe_ff       <= probe_in;
      limit_ff       <= limit_in;
      div_ff         <= div_in;
      bit_idx_ff     <= bit_idx_in;
      verdict_ff     <= verdict_in;
      factor_ff      <= factor_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_factor_ff  <= rsp_factor_in;
   end

   `TDPC_ASSERT(a_special_short, clock, reset, req_fire && (req_number[VALUE_BITS-1:1] == '0) |=> state_ff == ST_FINISH, "special word did not go straight to finish")
   `TDPC_ASSERT(a_div_holds, clock, reset, (state_ff == ST_DIV) && (bit_idx_ff != '0) |=> state_ff == ST_DIV, "divide sequence left early")
   `TDPC_ASSERT(a_range_prime, clock, reset, (state_ff == ST_CHECK) && !sub_ge |=> (state_ff == ST_FINISH) && (verdict_ff == VERDICT_PRIME), "divisor past root did not give prime")
   `TDPC_ASSERT(a_special_zero, clock, reset, rsp_valid_ff && (rsp_verdict_ff == VERDICT_SPECIAL) |-> rsp_factor_ff == '0, "special word with nonzero factor")
   `TDPC_ASSERT_ALWAYS(a_no_code3, clock, rsp_valid_ff |-> rsp_verdict_ff != 2'd3, "unused verdict code on output")
endmodule
`default_nettype wire

[sim/testbench.sv]
// Testbench for the trial division prime classifier: directed table, then random words.
`timescale 1ns / 1ps

module testbench;
   import tdpc_pkg::*;

   typedef struct packed {
      logic [1:0]  verdict;
      logic [31:0] factor;
   } outcome_type;

   typedef struct {
      logic [31:0] number;
      bit          typed;
      outcome_type want;
   } plan_row_type;

   localparam int PLAN_ROWS = 20;
   localparam int RANDOM_WORDS = 100;
   localparam int LONG_HOLD_CYCLES = 300;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_number;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_verdict;
   logic [31:0] rsp_smallest_factor;

   outcome_type verdicts_due[$];
   int       error_count = 0;
   int       words_out = 0;
   int       burst_left = 0;

   plan_row_type plan [PLAN_ROWS] = '{
      '{32'd0,          1'b1, '{VERDICT_SPECIAL,   32'd0}},
      '{32'd1,          1'b1, '{VERDICT_SPECIAL,   32'd0}},
      '{32'd2,          1'b1, '{VERDICT_PRIME,     32'd2}},
      '{32'd3,          1'b1, '{VERDICT_PRIME,     32'd3}},
      '{32'd4,          1'b1, '{VERDICT_COMPOSITE, 32'd2}},
      '{32'd5,          1'b0, '{VERDICT_SPECIAL,   32'd0}},
      '{32'd7,          1'b0, '{VERDICT_SPECIAL,   32'd0}},
      '{32'd8,          1'b0, '{VERDICT_SPECIAL,   32'd0}},
      '{32'd9,          1'b0, '{VERDICT_SPECIAL,   32'd0}},
      '{32'd15,         1'b0, '{VERDICT_SPECIAL,   32'd0}},
      '{32'd25,         1'b0, '{VERDICT_SPECIAL,   32'd0}},
      '{32'd49,         1'b0, '{VERDICT_SPECIAL,   32'd0}},
      '{32'hFFFFFFFF,   1'b1, '{VERDICT_COMPOSITE, 32'd3}},
      '{32'hFFFFFFFE,   1'b1, '{VERDICT_COMPOSITE, 32'd2}},
      '{32'h80000000,   1'b1, '{VERDICT_COMPOSITE, 32'd2}},
      '{32'hAAAAAAAA,   1'b1, '{VERDICT_COMPOSITE, 32'd2}},
      '{32'h55555555,   1'b0, '{VERDICT_SPECIAL,   32'd0}},
      '{32'd63001,      1'b0, '{VERDICT_SPECIAL,   32'd0}},
      '{32'd1052651,    1'b0, '{VERDICT_SPECIAL,   32'd0}},
      '{32'd268435399,  1'b0, '{VERDICT_SPECIAL,   32'd0}}
   };

   trial_division_prime_classifier_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_number          (req_number),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_verdict         (rsp_verdict),
      .rsp_smallest_factor (rsp_smallest_factor)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic outcome_type classify_number(input logic [31:0] n);
      outcome_type o;
      logic [31:0] root;
      logic [31:0] trial;
      logic [63:0] square;
      root = '0;
      o.verdict = VERDICT_PRIME;
      o.factor = n;
      if (n < 32'd2) begin
         o.verdict = VERDICT_SPECIAL;
         o.factor = '0;
         return o;
      end
      for (int b = 15; b >= 0; b--) begin
         trial = root | (32'd1 << b);
         square = 64'(trial) * 64'(trial);
         if (square <= 64'(n))
            root = trial;
      end
      for (trial = 32'd2; trial <= root; trial++) begin
         if (n % trial == 0) begin
            o.verdict = VERDICT_COMPOSITE;
            o.factor = trial;
            return o;
         end
      end
      return o;
   endfunction

   // Full-width words are kept only when a small factor ends the search early.
   function automatic logic [31:0] pick_number();
      logic [31:0]  n;
      outcome_type  o;
      int unsigned  sel;
      sel = $urandom_range(0, 9);
      if (sel < 4)
         return $urandom_range(0, 1023);
      if (sel < 6)
         return $urandom_range(0, 20'hFFFFF);
      do begin
         n = $urandom;
         o = classify_number(n);
      end while (o.verdict != VERDICT_COMPOSITE || o.factor > 32'd256);
      return n;
   endfunction

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic offer_word(input logic [31:0] value, input outcome_type want);
      if (burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_valid = 1'b1;
      req_number = value;
      do @(posedge clock); while (!req_ready);
      verdicts_due.push_back(want);
      @(negedge clock);
   endtask

   initial begin
      logic [31:0] value;
      reset = 1'b1;
      req_valid = 1'b0;
      req_number = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (int i = 0; i < PLAN_ROWS; i++)
         offer_word(plan[i].number,
                    plan[i].typed ? plan[i].want : classify_number(plan[i].number));
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == RANDOM_WORDS / 2) begin
            req_valid = 1'b0;
            while (verdicts_due.size() != 0) @(negedge clock);
         end
         value = pick_number();
         offer_word(value, classify_number(value));
      end
      req_valid = 1'b0;
      while (verdicts_due.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Receiver: phases of full, random and sparse ready, with one long hold once four words are out.
   initial begin
      int  phase_left;
      int  phase_mode;
      bit  long_hold_done;
      phase_left = 0;
      phase_mode = 0;
      long_hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!long_hold_done && words_out >= 4) begin
            rsp_ready = 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            long_hold_done = 1'b1;
         end
         if (phase_left == 0) begin
            phase_mode = $urandom_range(0, 2);
            phase_left = $urandom_range(1, 40);
         end
         phase_left--;
         case (phase_mode)
            0: rsp_ready = 1'b1;
            1: rsp_ready = 1'($urandom_range(0, 1));
            default: rsp_ready = ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      outcome_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         words_out <= words_out + 1;
         if (verdicts_due.size() == 0) begin
            $display("%0t: unexpected word, verdict %0d factor %0d",
                     $time, rsp_verdict, rsp_smallest_factor);
            error_count++;
         end else begin
            due = verdicts_due.pop_front();
            if (rsp_verdict !== due.verdict) begin
               $display("%0t: verdict expected %0d got %0d", $time, due.verdict, rsp_verdict);
               error_count++;
            end
            if (rsp_smallest_factor !== due.factor) begin
               $display("%0t: factor expected %0d got %0d",
                        $time, due.factor, rsp_smallest_factor);
               error_count++;
            end
         end
      end
   end
endmodule
